// ----- rtl/price_range_and_median_defines.svh -----
// ----------------------------------------------------------------------------
// price range and median assertion macros
// shared concurrent assertion forms, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef PRICE_RANGE_AND_MEDIAN_DEFINES_SVH
`define PRICE_RANGE_AND_MEDIAN_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PRM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prm assertion failed");
// next-cycle implication
`define PRM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prm assertion failed");
`else
`define PRM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PRM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/prm_pkg.sv -----
// ----------------------------------------------------------------------------
// prm_pkg
// widths, constants and types shared by the price range and median block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

   localparam int PRICE_W         = 18;
   localparam int GRID_W          = 14;
   localparam int EXT_W           = 20;
   localparam int STORE_DEPTH_DEF = 64;
   localparam int DIV_STEPS       = PRICE_W;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

   localparam logic [GRID_W-1:0]       GRID_RESET = GRID_W'(500);
   localparam logic signed [EXT_W-1:0] MIN_SPAN   = EXT_W'(1000);
   localparam logic signed [EXT_W-1:0] SAT_MIN    = EXT_W'(-(2 ** (PRICE_W - 1)));
   localparam logic signed [EXT_W-1:0] SAT_MAX    = EXT_W'((2 ** (PRICE_W - 1)) - 1);

   typedef logic signed [PRICE_W-1:0] price_type;
   typedef logic [GRID_W-1:0]         grid_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_LOAD,
      BK_SWEEP,
      BK_CHECK,
      BK_DIV_LO,
      BK_WAIT_LO,
      BK_DIV_HI,
      BK_WAIT_HI,
      BK_FINISH
   } back_state_type;

endpackage

`default_nettype wire

// ----- rtl/prm_req_if.sv -----
// ----------------------------------------------------------------------------
// prm_req_if
// price input channel: one price per transaction, last one of a set marked
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prm_req_if;
   import prm_pkg::*;

   logic      valid;
   logic      ready;
   price_type price;
   logic      last_item;

   modport source (output valid, output price, output last_item, input ready);
   modport sink   (input valid, input price, input last_item, output ready);
endinterface

`default_nettype wire

// ----- rtl/prm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// prm_rsp_if
// result channel: axis bounds, upper median and overflow flag of one set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prm_rsp_if;
   import prm_pkg::*;

   logic      valid;
   logic      ready;
   price_type axis_low;
   price_type axis_high;
   price_type median_price;
   logic      overflowed;

   modport source (output valid, output axis_low, output axis_high,
                   output median_price, output overflowed, input ready);
   modport sink   (input valid, input axis_low, input axis_high,
                   input median_price, input overflowed, output ready);
endinterface

`default_nettype wire

// ----- rtl/prm_csr_if.sv -----
// ----------------------------------------------------------------------------
// prm_csr_if
// configuration write channel carrying the grid interval
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prm_csr_if;
   import prm_pkg::*;

   logic     valid;
   logic     ready;
   grid_type grid_interval;

   modport source (output valid, output grid_interval, input ready);
   modport sink   (input valid, input grid_interval, output ready);
endinterface

`default_nettype wire

// ----- rtl/prm_front.sv -----
// ----------------------------------------------------------------------------
// prm_front
// takes prices, writes them to the store bank being filled, keeps running
// min and max, and hands a finished set to the back end as a job
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "price_range_and_median_defines.svh"

module prm_front #(
   parameter int STORE_DEPTH = prm_pkg::STORE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   prm_req_if.sink                                req_ch,
   output logic                                   mem_we,
   output logic [$clog2(STORE_DEPTH):0]           mem_waddr,
   output logic signed [prm_pkg::PRICE_W-1:0]     mem_wdata,
   output logic                                   job_push,
   output logic [2*prm_pkg::PRICE_W+$clog2(STORE_DEPTH+1)+1:0] job_data,
   input  logic                                   bank_release
);
   import prm_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   price_type        min_ff, min_in;
   price_type        max_ff, max_in;

   logic             accept;
   logic             has_room;
   logic             first;
   price_type        new_min;
   price_type        new_max;
   logic [CNT_W-1:0] next_cnt;
   logic             next_ovf;
   price_type        next_min;
   price_type        next_max;

   // two banks: at most two finished sets may be pending in the back end
   assign req_ch.ready = (busy_ff < 2'd2);
   assign accept       = req_ch.valid && req_ch.ready;
   assign has_room     = (cnt_ff < CNT_W'(STORE_DEPTH));
   assign first        = (cnt_ff == '0);

   assign new_min  = (first || (req_ch.price < min_ff)) ? req_ch.price : min_ff;
   assign new_max  = (first || (req_ch.price > max_ff)) ? req_ch.price : max_ff;
   assign next_cnt = has_room ? (cnt_ff + CNT_W'(1)) : cnt_ff;
   assign next_ovf = ovf_ff || !has_room;
   assign next_min = has_room ? new_min : min_ff;
   assign next_max = has_room ? new_max : max_ff;

   assign mem_waddr = {bank_ff, cnt_ff[ADDR_W-1:0]};
   assign mem_wdata = req_ch.price;
   assign job_data  = {bank_ff, next_ovf, next_cnt, next_max, next_min};

   always_comb begin
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      bank_in  = bank_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      mem_we   = 1'b0;
      job_push = 1'b0;
      if (accept) begin
         mem_we = has_room;
         cnt_in = next_cnt;
         ovf_in = next_ovf;
         min_in = next_min;
         max_in = next_max;
         if (req_ch.last_item) begin
            job_push = 1'b1;
            cnt_in   = '0;
            ovf_in   = 1'b0;
            bank_in  = !bank_ff;
         end
      end
      case ({job_push, bank_release})
         2'b10:   busy_in = busy_ff + 2'd1;
         2'b01:   busy_in = busy_ff - 2'd1;
         default: busy_in = busy_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
   end

   `PRM_ASSERT_IMP(a_busy_range, clock, reset, 1'b1, busy_ff != 2'd3)
   `PRM_ASSERT_IMP(a_release_owned, clock, reset, bank_release, busy_ff != 2'd0)

endmodule

`default_nettype wire

// ----- rtl/prm_queue.sv -----
// ----------------------------------------------------------------------------
// prm_queue
// two-entry job queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "price_range_and_median_defines.svh"

module prm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             full;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PRM_ASSERT_IMP(a_no_overrun, clock, reset, push, !full)
   `PRM_ASSERT_IMP(a_no_underrun, clock, reset, pop, !empty)

endmodule

`default_nettype wire

// ----- rtl/prm_div.sv -----
// ----------------------------------------------------------------------------
// prm_div
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [prm_pkg::PRICE_W-1:0]   dividend,
   input  logic [prm_pkg::GRID_W-1:0]    divisor,
   output logic                          done,
   output logic [prm_pkg::GRID_W-1:0]    remainder
);
   import prm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [PRICE_W-1:0]   num_ff, num_in;
   logic [GRID_W-1:0]    rem_ff, rem_in;
   logic [GRID_W-1:0]    dvs_ff, dvs_in;

   logic [GRID_W:0]      trial;
   logic [GRID_W:0]      diff;
   logic                 fits;

   assign trial     = {rem_ff, num_ff[PRICE_W-1]};
   assign diff      = trial - {1'b0, dvs_ff};
   assign fits      = (trial >= {1'b0, dvs_ff});
   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         num_in  = {num_ff[PRICE_W-2:0], 1'b0};
         rem_in  = fits ? diff[GRID_W-1:0] : trial[GRID_W-1:0];
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

endmodule

`default_nettype wire

// ----- rtl/prm_back.sv -----
// ----------------------------------------------------------------------------
// prm_back
// owns the price store, finds the upper median by rank counting and rounds
// min and max onto the grid, then holds the result for the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "price_range_and_median_defines.svh"

module prm_back #(
   parameter int STORE_DEPTH = prm_pkg::STORE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   mem_we,
   input  logic [$clog2(STORE_DEPTH):0]           mem_waddr,
   input  logic signed [prm_pkg::PRICE_W-1:0]     mem_wdata,
   input  logic                                   job_empty,
   output logic                                   job_pop,
   input  logic [2*prm_pkg::PRICE_W+$clog2(STORE_DEPTH+1)+1:0] job_data,
   input  logic [prm_pkg::GRID_W-1:0]             grid,
   output logic                                   bank_release,
   prm_rsp_if.source                              rsp_ch
);
   import prm_pkg::*;

   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int MEM_DEPTH = 2 * (2 ** ADDR_W);

   price_type mem [MEM_DEPTH];
   price_type rd_a_ff;
   price_type rd_b_ff;

   back_state_type state_ff, state_in;

   price_type          job_min_ff, job_min_in;
   price_type          job_max_ff, job_max_in;
   logic [CNT_W-1:0]   job_cnt_ff, job_cnt_in;
   logic               job_ovf_ff, job_ovf_in;
   logic               job_bank_ff, job_bank_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   lt_ff, lt_in;
   logic [CNT_W-1:0]   le_ff, le_in;
   logic               cmp_vld_ff, cmp_vld_in;
   price_type          med_ff, med_in;
   logic [GRID_W-1:0]  rem_lo_ff, rem_lo_in;
   logic signed [EXT_W-1:0] lo_ff, lo_in;
   logic signed [EXT_W-1:0] hi_ff, hi_in;
   logic               rsp_vld_ff, rsp_vld_in;
   price_type          rsp_lo_ff, rsp_lo_in;
   price_type          rsp_hi_ff, rsp_hi_in;
   price_type          rsp_med_ff, rsp_med_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [ADDR_W:0]    addr_a;
   logic [ADDR_W:0]    addr_b;
   logic [CNT_W-1:0]   rank;
   logic               out_free;
   logic               div_start;
   logic [PRICE_W-1:0] div_dividend;
   logic               div_done;
   logic [GRID_W-1:0]  div_rem;
   logic [PRICE_W-1:0] mag_min;
   logic [PRICE_W-1:0] mag_max;

   logic signed [EXT_W-1:0] min_x, max_x;
   logic signed [EXT_W-1:0] g_x, m_lo_x, m_hi_x;
   logic signed [EXT_W-1:0] span;
   logic signed [EXT_W-1:0] hi_adj;
   logic signed [EXT_W-1:0] lo_sat, hi_sat;

   // store: one write port from the front, two registered read ports
   assign addr_a = {job_bank_ff, i_ff[ADDR_W-1:0]};
   assign addr_b = {job_bank_ff, j_ff[ADDR_W-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   assign rank     = job_cnt_ff >> 1;
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   assign mag_min = job_min_ff[PRICE_W-1] ? (~job_min_ff + PRICE_W'(1)) : job_min_ff;
   assign mag_max = job_max_ff[PRICE_W-1] ? (~job_max_ff + PRICE_W'(1)) : job_max_ff;
   assign div_dividend = (state_ff == BK_DIV_LO) ? mag_min : mag_max;

   prm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (grid),
      .done      (div_done),
      .remainder (div_rem)
   );

   // rounding: remainder magnitudes follow the sign of the operand
   assign min_x  = {{(EXT_W-PRICE_W){job_min_ff[PRICE_W-1]}}, job_min_ff};
   assign max_x  = {{(EXT_W-PRICE_W){job_max_ff[PRICE_W-1]}}, job_max_ff};
   assign g_x    = {{(EXT_W-GRID_W){1'b0}}, grid};
   assign m_lo_x = {{(EXT_W-GRID_W){1'b0}}, rem_lo_ff};
   assign m_hi_x = {{(EXT_W-GRID_W){1'b0}}, div_rem};

   assign span   = hi_ff - lo_ff;
   assign hi_adj = (span < MIN_SPAN) ? (lo_ff + MIN_SPAN) : hi_ff;
   assign lo_sat = (lo_ff < SAT_MIN) ? SAT_MIN : ((lo_ff > SAT_MAX) ? SAT_MAX : lo_ff);
   assign hi_sat = (hi_adj < SAT_MIN) ? SAT_MIN : ((hi_adj > SAT_MAX) ? SAT_MAX : hi_adj);

   always_comb begin
      state_in     = state_ff;
      job_min_in   = job_min_ff;
      job_max_in   = job_max_ff;
      job_cnt_in   = job_cnt_ff;
      job_ovf_in   = job_ovf_ff;
      job_bank_in  = job_bank_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lt_in        = lt_ff;
      le_in        = le_ff;
      cmp_vld_in   = cmp_vld_ff;
      med_in       = med_ff;
      rem_lo_in    = rem_lo_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ch.ready;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      job_pop      = 1'b0;
      div_start    = 1'b0;
      bank_release = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               job_pop     = 1'b1;
               job_min_in  = job_data[PRICE_W-1:0];
               job_max_in  = job_data[2*PRICE_W-1:PRICE_W];
               job_cnt_in  = job_data[2*PRICE_W+CNT_W-1:2*PRICE_W];
               job_ovf_in  = job_data[2*PRICE_W+CNT_W];
               job_bank_in = job_data[2*PRICE_W+CNT_W+1];
               i_in        = '0;
               state_in    = BK_LOAD;
            end
         end
         BK_LOAD: begin
            // candidate read lands in rd_a_ff for the sweep
            j_in       = '0;
            lt_in      = '0;
            le_in      = '0;
            cmp_vld_in = 1'b0;
            state_in   = BK_SWEEP;
         end
         BK_SWEEP: begin
            cmp_vld_in = (j_ff < job_cnt_ff);
            if (j_ff < job_cnt_ff) begin
               j_in = j_ff + CNT_W'(1);
            end
            if (cmp_vld_ff) begin
               lt_in = lt_ff + CNT_W'(rd_b_ff < rd_a_ff);
               le_in = le_ff + CNT_W'(rd_b_ff <= rd_a_ff);
            end
            if (j_ff == job_cnt_ff) begin
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            // candidate holds rank n/2 when lt <= n/2 < le
            if (((lt_ff <= rank) && (rank < le_ff)) ||
                (i_ff == (job_cnt_ff - CNT_W'(1)))) begin
               med_in   = rd_a_ff;
               state_in = BK_DIV_LO;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = BK_LOAD;
            end
         end
         BK_DIV_LO: begin
            div_start = 1'b1;
            state_in  = BK_WAIT_LO;
         end
         BK_WAIT_LO: begin
            if (div_done) begin
               rem_lo_in = div_rem;
               state_in  = BK_DIV_HI;
            end
         end
         BK_DIV_HI: begin
            div_start = 1'b1;
            state_in  = BK_WAIT_HI;
         end
         BK_WAIT_HI: begin
            if (div_done) begin
               if (!job_min_ff[PRICE_W-1]) begin
                  lo_in = min_x - m_lo_x;
               end else if (rem_lo_ff != '0) begin
                  lo_in = min_x + m_lo_x - g_x;
               end else begin
                  lo_in = min_x;
               end
               if (job_max_ff[PRICE_W-1]) begin
                  hi_in = max_x + m_hi_x;
               end else if (div_rem != '0) begin
                  hi_in = max_x - m_hi_x + g_x;
               end else begin
                  hi_in = max_x;
               end
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_lo_in    = lo_sat[PRICE_W-1:0];
               rsp_hi_in    = hi_sat[PRICE_W-1:0];
               rsp_med_in   = med_ff;
               rsp_ovf_in   = job_ovf_ff;
               bank_release = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_min_ff  <= job_min_in;
      job_max_ff  <= job_max_in;
      job_cnt_ff  <= job_cnt_in;
      job_ovf_ff  <= job_ovf_in;
      job_bank_ff <= job_bank_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      med_ff      <= med_in;
      rem_lo_ff   <= rem_lo_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_med_ff  <= rsp_med_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.axis_low     = rsp_lo_ff;
   assign rsp_ch.axis_high    = rsp_hi_ff;
   assign rsp_ch.median_price = rsp_med_ff;
   assign rsp_ch.overflowed   = rsp_ovf_ff;

   `PRM_ASSERT_IMP(a_cand_in_set, clock, reset, state_ff == BK_LOAD, i_ff < job_cnt_ff)
   `PRM_ASSERT_IMP(a_rank_counts, clock, reset, state_ff == BK_CHECK, (lt_ff <= le_ff) && (le_ff <= job_cnt_ff))
   `PRM_ASSERT_NXT(a_release_result, clock, reset, bank_release, rsp_vld_ff && (state_ff == BK_IDLE))

endmodule

`default_nettype wire

// ----- rtl/price_range_and_median.sv -----
// load: one price transaction per cycle unless two sets are pending; a second set can load while the first is worked on
// after the last price: per tried candidate a load, a sweep and a check, at worst for all n,
// then two remainder passes (min, then max) and the result register, n = stored prices
// the rank search is bound by the two read ports of the store, one compare per cycle
// reset (synchronous, active high) empties the queue and counters and sets grid to 500;
// the store itself is not cleared
// ----------------------------------------------------------------------------
// price_range_and_median
// axis range from min and max rounded to the grid, plus the upper median
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module price_range_and_median #(
   parameter int STORE_DEPTH = prm_pkg::STORE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   prm_req_if.sink    req_ch,
   prm_rsp_if.source  rsp_ch,
   prm_csr_if.sink    csr_ch
);
   import prm_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int JOB_W  = 2 * PRICE_W + CNT_W + 2;

   grid_type grid_ff, grid_in;
   grid_type grid_eff;

   logic              mem_we;
   logic [ADDR_W:0]   mem_waddr;
   price_type         mem_wdata;
   logic              job_push;
   logic [JOB_W-1:0]  job_push_data;
   logic              job_pop;
   logic [JOB_W-1:0]  job_pop_data;
   logic              job_empty;
   logic              bank_release;

   assign csr_ch.ready = 1'b1;
   assign grid_in      = csr_ch.valid ? csr_ch.grid_interval : grid_ff;
   // zero interval means no rounding
   assign grid_eff     = (grid_ff == '0) ? GRID_W'(1) : grid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= GRID_RESET;
      end else begin
         grid_ff <= grid_in;
      end
   end

   prm_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .job_push     (job_push),
      .job_data     (job_push_data),
      .bank_release (bank_release)
   );

   prm_queue #(.WIDTH(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .pop_data  (job_pop_data),
      .empty     (job_empty)
   );

   prm_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .job_empty    (job_empty),
      .job_pop      (job_pop),
      .job_data     (job_pop_data),
      .grid         (grid_eff),
      .bank_release (bank_release),
      .rsp_ch       (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- sim/price_range_and_median_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_range_and_median_tb
// loads price sets into the block and checks the axis bounds, upper median
// and overflow flag of each set against a predictor in the bench. A short
// table of directed sets comes first, followed by random sets under several
// grid settings. Both channels stall at random, but not in phase 3 or the last phase.
// ----------------------------------------------------------------------------

module price_range_and_median_tb;
   import prm_pkg::*;

   localparam int     STORE_DEPTH       = STORE_DEPTH_DEF;
   localparam longint MIN_AXIS_SPAN     = 1000;
   localparam longint AXIS_FLOOR        = -(longint'(1) << (PRICE_W - 1));
   localparam longint AXIS_CEILING      = (longint'(1) << (PRICE_W - 1)) - 1;
   localparam int     RESET_CYCLES      = 4;
   localparam int     SETTLE_CYCLES     = 64;
   localparam int     NUM_PHASES        = 8;
   localparam int     ITEMS_PER_PHASE   = 175;
   // the watchdog must outlast the rank search of a full store
   localparam int     WATCHDOG_LIMIT    = 40000;
   localparam int     NUM_DIRECTED_ROWS = 27;

   typedef enum logic [0:0] {
      ROW_PRICE,
      ROW_GRID
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      int           value;
      int           reps;
      logic         last;
      logic         fixed_exp;
      int           axis_low;
      int           axis_high;
      int           median_price;
      logic         overflowed;
   } stim_row_type;

   typedef struct packed {
      price_type axis_low;
      price_type axis_high;
      price_type median_price;
      logic      overflowed;
   } set_summary_type;

   // kind, value, reps, last, fixed expectation, low, high, median, overflow
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED_ROWS] = '{
      '{ROW_PRICE,       0,  1, 1'b1, 1'b1,       0,    1000,       0, 1'b0},
      '{ROW_PRICE,  131071,  1, 1'b1, 1'b1,  131000,  131071,  131071, 1'b0},
      '{ROW_PRICE, -131072,  1, 1'b1, 1'b1, -131072, -130500, -131072, 1'b0},
      '{ROW_PRICE, -100000,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,  100000,  1, 1'b1, 1'b1, -100000,  100000,  100000, 1'b0},
      '{ROW_PRICE,     300,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,    -250,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,    1234,  1, 1'b1, 1'b1,    -500,    1500,     300, 1'b0},
      '{ROW_PRICE,       7,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,       3,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,       9,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,       1,  1, 1'b1, 1'b1,       0,    1000,       7, 1'b0},
      '{ROW_PRICE,   87381,  1, 1'b1, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,  -87382,  1, 1'b1, 1'b0,       0,       0,       0, 1'b0},
      // fill the store, then a marked price that gets dropped
      '{ROW_PRICE,      42, 64, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,  -90000,  1, 1'b1, 1'b1,       0,    1000,      42, 1'b1},
      '{ROW_PRICE,       7,  1, 1'b1, 1'b1,       0,    1000,       7, 1'b0},
      '{ROW_GRID,        0,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,   12345,  1, 1'b1, 1'b1,   12345,   13345,   12345, 1'b0},
      '{ROW_GRID,    10000,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,      -1,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,       1,  1, 1'b1, 1'b1,  -10000,   10000,       1, 1'b0},
      '{ROW_GRID,    16383,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,       5,  1, 1'b1, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_GRID,        1,  1, 1'b0, 1'b0,       0,       0,       0, 1'b0},
      '{ROW_PRICE,     100,  1, 1'b1, 1'b1,     100,    1100,     100, 1'b0},
      '{ROW_PRICE,  131071,  1, 1'b1, 1'b1,  131071,  131071,  131071, 1'b0}
   };

   logic clock;
   logic reset;

   prm_req_if req_if ();
   prm_rsp_if rsp_if ();
   prm_csr_if csr_if ();

   price_range_and_median dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predictor state
   price_type price_mem [STORE_DEPTH];
   int        stored_n     = 0;
   price_type low_seen     = '0;
   price_type high_seen    = '0;
   logic      dropped_seen = 1'b0;
   grid_type  grid_setting = GRID_RESET;

   set_summary_type summary_q [$];
   int              mismatch_count = 0;
   int              stuck_cycles   = 0;
   logic            idling_on      = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // folds one accepted price into the set; on the marked price works out the summary
   task automatic compute_axis_and_median(input price_type value, input logic last,
                                          output logic produced,
                                          output set_summary_type summary);
      longint    g;
      longint    lo;
      longint    hi;
      longint    r;
      price_type sorted [STORE_DEPTH];
      price_type v;
      int        j;
      produced = 1'b0;
      summary  = '0;
      if (stored_n < STORE_DEPTH) begin
         price_mem[stored_n] = value;
         if (stored_n == 0 || value < low_seen) low_seen = value;
         if (stored_n == 0 || value > high_seen) high_seen = value;
         stored_n++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (last) begin
         g  = (grid_setting == 0) ? 1 : longint'(grid_setting);
         r  = longint'(low_seen) % g;
         lo = (r < 0) ? longint'(low_seen) - r - g : longint'(low_seen) - r;
         r  = longint'(high_seen) % g;
         hi = (r > 0) ? longint'(high_seen) - r + g : longint'(high_seen) - r;
         if (hi - lo < MIN_AXIS_SPAN) hi = lo + MIN_AXIS_SPAN;
         // span rule first, then clamp to the field
         if (lo < AXIS_FLOOR) lo = AXIS_FLOOR;
         if (lo > AXIS_CEILING) lo = AXIS_CEILING;
         if (hi < AXIS_FLOOR) hi = AXIS_FLOOR;
         if (hi > AXIS_CEILING) hi = AXIS_CEILING;
         for (int i = 0; i < stored_n; i++) begin
            v = price_mem[i];
            j = i;
            while (j > 0 && sorted[j - 1] > v) begin
               sorted[j] = sorted[j - 1];
               j--;
            end
            sorted[j] = v;
         end
         summary.axis_low     = price_type'(lo);
         summary.axis_high    = price_type'(hi);
         summary.median_price = sorted[stored_n / 2];
         summary.overflowed   = dropped_seen;
         produced     = 1'b1;
         stored_n     = 0;
         dropped_seen = 1'b0;
      end
   endtask

   task automatic send_price(input price_type value, input logic last, input logic use_row,
                             input set_summary_type row_summary);
      logic            produced;
      set_summary_type predicted;
      req_if.valid     <= 1'b1;
      req_if.price     <= value;
      req_if.last_item <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      compute_axis_and_median(value, last, produced, predicted);
      if (produced) summary_q.push_back(use_row ? row_summary : predicted);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (summary_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid(input grid_type value);
      csr_if.valid         <= 1'b1;
      csr_if.grid_interval <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      grid_setting = value;
   endtask

   // result side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      set_summary_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (summary_q.size() == 0) begin
            report_mismatch("result with no set pending, axis_low", rsp_if.axis_low, 0);
         end else begin
            want = summary_q.pop_front();
            if (rsp_if.axis_low !== want.axis_low)
               report_mismatch("axis_low", rsp_if.axis_low, want.axis_low);
            if (rsp_if.axis_high !== want.axis_high)
               report_mismatch("axis_high", rsp_if.axis_high, want.axis_high);
            if (rsp_if.median_price !== want.median_price)
               report_mismatch("median_price", rsp_if.median_price, want.median_price);
            if (rsp_if.overflowed !== want.overflowed)
               report_mismatch("overflowed", rsp_if.overflowed, want.overflowed);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("price_range_and_median test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      stim_row_type    row;
      set_summary_type row_summary;
      int              phase_items;
      int              set_len;
      int              pick;
      int              style;
      price_type       base;
      price_type       value;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.price         <= '0;
      req_if.last_item     <= 1'b0;
      csr_if.valid         <= 1'b0;
      csr_if.grid_interval <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed sets at the reset grid and at the grid extremes
      for (int i = 0; i < NUM_DIRECTED_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_GRID) begin
            wait_for_results();
            write_grid(grid_type'(row.value));
         end else begin
            row_summary.axis_low     = price_type'(row.axis_low);
            row_summary.axis_high    = price_type'(row.axis_high);
            row_summary.median_price = price_type'(row.median_price);
            row_summary.overflowed   = row.overflowed;
            for (int k = 0; k < row.reps; k++)
               send_price(price_type'(row.value), row.last && (k == row.reps - 1),
                          row.fixed_exp, row_summary);
         end
      end

      // random sets, one grid setting per phase
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_results();
         idling_on = (phase != 3) && (phase != NUM_PHASES - 1);
         case (phase)
            0:       write_grid(grid_type'(1));
            1:       write_grid(grid_type'(10000));
            2:       write_grid(grid_type'(0));
            3:       write_grid('1);
            4:       write_grid(GRID_RESET);
            default: write_grid(grid_type'($urandom_range(1, 10000)));
         endcase
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) set_len = $urandom_range(1, 8);
            else if (pick < 90) set_len = $urandom_range(9, STORE_DEPTH - 1);
            else if (pick < 95) set_len = STORE_DEPTH;
            else set_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
            style = $urandom_range(0, 3);
            base  = price_type'($urandom_range(0, 200000) - 100000);
            for (int k = 0; k < set_len; k++) begin
               case (style)
                  0:       value = price_type'($urandom);
                  1:       value = price_type'($urandom_range(0, 200000) - 100000);
                  // narrow cluster so the minimum span rule kicks in
                  2:       value = base + price_type'($urandom_range(0, 1500));
                  default: begin
                     case ($urandom_range(0, 4))
                        0:       value = price_type'(AXIS_FLOOR);
                        1:       value = price_type'(AXIS_CEILING);
                        2:       value = '0;
                        3:       value = '1;
                        default: value = base;
                     endcase
                  end
               endcase
               send_price(value, k == set_len - 1, 1'b0, '0);
            end
            phase_items += set_len;
         end
      end

      wait_for_results();
      if (mismatch_count == 0) begin
         $display("price_range_and_median test passed");
      end else begin
         $display("price_range_and_median test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/prm_pkg.sv
rtl/prm_req_if.sv
rtl/prm_rsp_if.sv
rtl/prm_csr_if.sv
rtl/prm_front.sv
rtl/prm_queue.sv
rtl/prm_div.sv
rtl/prm_back.sv
rtl/price_range_and_median.sv
sim/price_range_and_median_tb.sv
